/* sv/spc_pkg.sv */
`default_nettype none

package spc_pkg;

   // store sizing
   localparam int MAX_ITEMS = 256;
   localparam int FIELD_W   = 9;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int DEPTH_W   = $clog2(MAX_ITEMS + 1);
   localparam int ENTRY_W   = $clog2(MAX_ITEMS + 2);
   localparam int WIN_W     = 2;
   localparam int CFG_RESET = 256;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_STEP
   } ctrl_state_type;

   // controller to stack
   typedef struct packed {
      logic               clear;
      logic               push;
      logic               pop;
      logic [FIELD_W-1:0] id;
      logic [WIN_W-1:0]   win;
   } stack_cmd_type;

   // stack to controller
   typedef struct packed {
      logic               busy;
      logic [DEPTH_W-1:0] depth;
      logic [FIELD_W-1:0] top_id;
      logic [WIN_W-1:0]   top_win;
   } stack_stat_type;

endpackage

`default_nettype wire

/* sv/spc_stack.sv */
`default_nettype none

module spc_stack
   import spc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stack_cmd_type  cmd,
   output stack_stat_type      stat
);

   logic [FIELD_W+WIN_W-1:0] stack_mem [MAX_ITEMS];
   logic [FIELD_W+WIN_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic                     refill_ff, refill_in;
   logic [FIELD_W-1:0]       top_id_ff, top_id_in;
   logic [WIN_W-1:0]         top_win_ff, top_win_in;

   // entry just below the current top
   assign rd_addr = ADDR_W'(depth_ff - DEPTH_W'(2));

   // store write on push, registered read every cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[depth_ff[ADDR_W-1:0]] <= {cmd.id, cmd.win};
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // depth and cached top entry
   always_comb begin
      depth_in   = depth_ff;
      refill_in  = 1'b0;
      top_id_in  = top_id_ff;
      top_win_in = top_win_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in   = depth_ff + DEPTH_W'(1);
         top_id_in  = cmd.id;
         top_win_in = cmd.win;
      end else if (cmd.pop) begin
         depth_in  = depth_ff - DEPTH_W'(1);
         refill_in = (depth_ff >= DEPTH_W'(2));
      end
      // after a pop that leaves one or more entries, the registered store read reloads the top
      if (refill_ff) begin
         top_id_in  = rd_data_ff[FIELD_W+WIN_W-1:WIN_W];
         top_win_in = rd_data_ff[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         refill_ff <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         refill_ff <= refill_in;
      end
      top_id_ff  <= top_id_in;
      top_win_ff <= top_win_in;
   end

   assign stat.busy    = refill_ff;
   assign stat.depth   = depth_ff;
   assign stat.top_id  = top_id_ff;
   assign stat.top_win = top_win_ff;

endmodule

`default_nettype wire

/* sv/stack_permutation_checker_top.sv */
// Channel   Direction  Signals                          Content
// req_      in         req_tvalid/tready/tdata/tuser    exit id, run start
// rsp_      out        rsp_tvalid/tready/tdata/tuser/tlast  item id, wins, bad, done
// csr_      in         csr_valid/ready/data             item_count
//
// A request is handled as an accept, then one push for each item to be pushed,
// then the pop, error or status step; the pushes are set by the exit order (at most item_count).
// A pop that leaves one or more entries reloads the cached top from the store's
// registered read port in the idle cycle that follows, so it does not hold up the next request.
// Synchronous reset clears control state; the store needs no clearing pass.
// A full response register holds the block in its final step until taken.
`default_nettype none

module stack_permutation_checker_top
   import spc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [8:0] exit_id, rest zero
   input  wire logic        req_tuser,   // [0] run_start
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [8:0] item_id, [17:9] win_count, rest zero
   output logic             rsp_tuser,   // [0] order_bad
   output logic             rsp_tlast,   // run_done
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data
);

   ctrl_state_type     state_ff, state_in;
   logic [FIELD_W-1:0] want_ff, want_in;
   logic [ENTRY_W-1:0] next_ff, next_in;
   logic [DEPTH_W-1:0] served_ff, served_in;
   logic               err_ff, err_in;
   logic [FIELD_W-1:0] cfg_ff;
   logic [DEPTH_W-1:0] count;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_id_ff, rsp_id_in;
   logic [FIELD_W-1:0] rsp_win_ff, rsp_win_in;
   logic               rsp_bad_ff, rsp_bad_in;
   logic               rsp_done_ff, rsp_done_in;

   stack_cmd_type      cmd;
   stack_stat_type     stat;

   logic               accept;
   logic               out_free;
   logic               top_hit;
   logic [DEPTH_W-1:0] served_inc;

   spc_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // configuration register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= FIELD_W'(CFG_RESET);
      end else if (csr_valid) begin
         cfg_ff <= csr_data;
      end
   end

   // live count saturated to 1..MAX_ITEMS
   always_comb begin
      if (cfg_ff == '0) begin
         count = DEPTH_W'(1);
      end else if (DEPTH_W'(cfg_ff) > DEPTH_W'(MAX_ITEMS)) begin
         count = DEPTH_W'(MAX_ITEMS);
      end else begin
         count = DEPTH_W'(cfg_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign top_hit    = (stat.depth != '0) && (stat.top_id == want_ff);
   assign served_inc = served_ff + DEPTH_W'(1);

   // sequencer: one push, pop or verdict per cycle when not stalled
   always_comb begin
      state_in     = state_ff;
      want_in      = want_ff;
      next_in      = next_ff;
      served_in    = served_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_done_in  = rsp_done_ff;
      cmd          = '0;
      cmd.id       = FIELD_W'(next_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               want_in   = req_tdata[FIELD_W-1:0];
               cmd.clear = req_tuser;
               if (req_tuser) begin
                  next_in   = ENTRY_W'(1);
                  served_in = '0;
                  err_in    = 1'b0;
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!stat.busy) begin
               if (err_ff || (served_ff >= count)) begin
                  // nothing to do: report run status only
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     rsp_win_in   = '0;
                     rsp_bad_in   = err_ff;
                     rsp_done_in  = !err_ff;
                     state_in     = ST_IDLE;
                  end
               end else if (ENTRY_W'(count) < next_ff) begin
                  // no entries left: top must match
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                     if (top_hit) begin
                        cmd.pop     = 1'b1;
                        served_in   = served_inc;
                        rsp_id_in   = stat.top_id;
                        rsp_win_in  = FIELD_W'(stat.top_win);
                        rsp_bad_in  = 1'b0;
                        rsp_done_in = (served_inc >= count);
                     end else begin
                        err_in      = 1'b1;
                        rsp_id_in   = '0;
                        rsp_win_in  = '0;
                        rsp_bad_in  = 1'b1;
                        rsp_done_in = 1'b0;
                     end
                  end
               end else if (stat.depth == '0) begin
                  // push onto empty store, no win
                  cmd.push = 1'b1;
                  cmd.win  = '0;
                  next_in  = next_ff + ENTRY_W'(1);
               end else if (top_hit) begin
                  // pop with entries remaining earns a win
                  if (out_free) begin
                     cmd.pop      = 1'b1;
                     served_in    = served_inc;
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = stat.top_id;
                     rsp_win_in   = FIELD_W'(stat.top_win + WIN_W'(1));
                     rsp_bad_in   = 1'b0;
                     rsp_done_in  = (served_inc >= count);
                     state_in     = ST_IDLE;
                  end
               end else begin
                  // push onto non-empty store, one win
                  cmd.push = 1'b1;
                  cmd.win  = WIN_W'(1);
                  next_in  = next_ff + ENTRY_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_ff      <= ENTRY_W'(1);
         served_ff    <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         served_ff    <= served_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff     <= want_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_win_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

`default_nettype wire

/* sv/spc_checker.sv */
`default_nettype none

module spc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // one request in flight: not ready right after an accept
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // no item left means no wins
   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:0] == 9'd0) |-> (rsp_tdata[23:9] == 15'd0))
      else $error("wins reported without an item");

   // bad order and run done never together
   a_bad_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tlast))
      else $error("order_bad and run_done both set");

endmodule

bind stack_permutation_checker_top spc_checker u_spc_checker (.*);

`default_nettype wire
